@@ hw/rtl/pidc_pkg.sv @@
// Package for the dead-band PID controller: widths, fixed-point format and
// configuration register indexes. No dependencies.
package pidc_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int GAIN_BITS      = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int ACC_BITS       = 40;
    localparam int LIMIT_BITS     = 15;
    localparam int DZONE_BITS     = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_IDX_BITS   = 3;

    localparam int ERR_W  = SAMPLE_BITS + 1;
    localparam int D1_W   = ERR_W + 1;
    localparam int D2_W   = ERR_W + 2;
    localparam int PROD_W = GAIN_BITS + D2_W;
    localparam int SUM_W  = ACC_BITS + 2;
    localparam int RAW_W  = SUM_W - GAIN_FRAC_BITS + 2;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = '1;

    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_PROP_GAIN   = 3'd0;
    localparam cfg_idx_t CFG_INTEG_GAIN  = 3'd1;
    localparam cfg_idx_t CFG_DERIV_GAIN  = 3'd2;
    localparam cfg_idx_t CFG_DRIVE_LIMIT = 3'd3;
    localparam cfg_idx_t CFG_DEAD_ZONE   = 3'd4;
    localparam cfg_idx_t CFG_LOOP_MODE   = 3'd5;

    typedef enum logic
    {
        MODE_POSITIONAL  = 1'b0,
        MODE_INCREMENTAL = 1'b1
    } loop_mode_t;

endpackage

@@ hw/rtl/pid_controller_deadband_dual_mode_top.sv @@
// Dead-band PID controller, positional and incremental forms, one pass per sample.
// Depends on pidc_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one measured sample and one target
//   per transaction. Output channel (out_valid/out_ready) returns one drive value
//   and a clamp flag per input transaction, in order.
//   out_valid rises in the cycle after input acceptance.
//   Throughput: 1 transaction per cycle; the error, the three gain multiplies,
//   the integral saturation and the clamp all complete in a single registered
//   pass, since integral and held drive feed back into the next sample.
//   in_ready is high whenever the output register is empty or is being taken
//   in the same cycle; a stalled receiver holds the result and stalls the input.
//   Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata), one
//   register per write, no read-back; write only while the block is idle.
//   Reset: gains, dead zone and mode clear to zero, drive limit to its maximum,
//   error history, integral and held drive clear, no result pending.
module pid_controller_deadband_dual_mode_top
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  pidc_pkg::cfg_idx_t                     cfg_index,
    input  logic [pidc_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [pidc_pkg::SAMPLE_BITS-1:0] measured,
    input  logic signed [pidc_pkg::SAMPLE_BITS-1:0] target,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [pidc_pkg::SAMPLE_BITS-1:0] drive,
    output logic                                   clamped
);
    import pidc_pkg::*;

    logic signed [GAIN_BITS-1:0]    prop_gain_reg;
    logic signed [GAIN_BITS-1:0]    integ_gain_reg;
    logic signed [GAIN_BITS-1:0]    deriv_gain_reg;
    logic [LIMIT_BITS-1:0]          drive_limit_reg;
    logic [DZONE_BITS-1:0]          dead_zone_reg;
    loop_mode_t                     loop_mode_reg;

    logic signed [ERR_W-1:0]        err_prev_reg;
    logic signed [ERR_W-1:0]        err_prev2_reg;
    logic signed [ACC_BITS-1:0]     integral_reg;
    logic signed [SAMPLE_BITS-1:0]  held_drive_reg;
    logic signed [ACC_BITS-1:0]     integral_next;
    logic signed [SAMPLE_BITS-1:0]  held_drive_next;

    logic                           out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]  drive_reg;
    logic                           clamped_reg;
    logic                           clamped_next;

    logic                           accept;
    logic signed [ERR_W-1:0]        err;
    logic [ERR_W-1:0]               err_mag;
    logic                           in_band;
    logic signed [D1_W-1:0]         diff1;
    logic signed [D2_W-1:0]         diff2;
    logic signed [D2_W-1:0]         prop_opnd;
    logic signed [D2_W-1:0]         deriv_opnd;
    logic signed [PROD_W-1:0]       prod_p;
    logic signed [PROD_W-1:0]       prod_i;
    logic signed [PROD_W-1:0]       prod_d;
    logic signed [ACC_BITS:0]       acc_sum;
    logic signed [ACC_BITS-1:0]     acc_sat;
    logic signed [SUM_W-1:0]        sum;
    logic signed [SUM_W-1:0]        sum_shift;
    logic signed [RAW_W-1:0]        raw;
    logic signed [RAW_W-1:0]        lim_pos;
    logic signed [RAW_W-1:0]        lim_neg;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign clamped   = clamped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            drive_limit_reg <= LIMIT_RESET;
            dead_zone_reg   <= '0;
            loop_mode_reg   <= MODE_POSITIONAL;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_PROP_GAIN:   prop_gain_reg   <= GAIN_BITS'(cfg_wdata);
                CFG_INTEG_GAIN:  integ_gain_reg  <= GAIN_BITS'(cfg_wdata);
                CFG_DERIV_GAIN:  deriv_gain_reg  <= GAIN_BITS'(cfg_wdata);
                CFG_DRIVE_LIMIT: drive_limit_reg <= cfg_wdata[LIMIT_BITS-1:0];
                CFG_DEAD_ZONE:   dead_zone_reg   <= cfg_wdata[DZONE_BITS-1:0];
                CFG_LOOP_MODE:   loop_mode_reg   <= loop_mode_t'(cfg_wdata[0]);
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        err     = ERR_W'(target) - ERR_W'(measured);
        err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        in_band = err_mag < {1'b0, dead_zone_reg};

        diff1 = D1_W'(err) - D1_W'(err_prev_reg);
        diff2 = D2_W'(err) - (D2_W'(err_prev_reg) <<< 1) + D2_W'(err_prev2_reg);

        if (loop_mode_reg == MODE_INCREMENTAL)
        begin
            prop_opnd  = D2_W'(diff1);
            deriv_opnd = diff2;
        end
        else
        begin
            prop_opnd  = D2_W'(err);
            deriv_opnd = D2_W'(diff1);
        end

        prod_p = PROD_W'(prop_gain_reg) * PROD_W'(prop_opnd);
        prod_i = PROD_W'(integ_gain_reg) * PROD_W'(err);
        prod_d = PROD_W'(deriv_gain_reg) * PROD_W'(deriv_opnd);

        acc_sum = (ACC_BITS+1)'(integral_reg) + (ACC_BITS+1)'(prod_i);
        if (acc_sum[ACC_BITS] != acc_sum[ACC_BITS-1])
            acc_sat = {acc_sum[ACC_BITS], {(ACC_BITS-1){!acc_sum[ACC_BITS]}}};
        else
            acc_sat = acc_sum[ACC_BITS-1:0];

        if (loop_mode_reg == MODE_INCREMENTAL)
            sum = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
        else
            sum = SUM_W'(prod_p) + SUM_W'(acc_sat) + SUM_W'(prod_d);

        sum_shift = sum >>> GAIN_FRAC_BITS;
        raw       = RAW_W'(sum_shift);
        if (loop_mode_reg == MODE_INCREMENTAL)
            raw = raw + RAW_W'(held_drive_reg);

        lim_pos = RAW_W'(signed'({1'b0, drive_limit_reg}));
        lim_neg = -lim_pos;

        if (in_band)
        begin
            integral_next   = integral_reg;
            held_drive_next = '0;
            clamped_next    = 1'b0;
        end
        else if (raw > lim_pos)
        begin
            integral_next   = acc_sat;
            held_drive_next = SAMPLE_BITS'(lim_pos);
            clamped_next    = 1'b1;
        end
        else if (raw < lim_neg)
        begin
            integral_next   = acc_sat;
            held_drive_next = SAMPLE_BITS'(lim_neg);
            clamped_next    = 1'b1;
        end
        else
        begin
            integral_next   = acc_sat;
            held_drive_next = SAMPLE_BITS'(raw);
            clamped_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_prev_reg   <= '0;
            err_prev2_reg  <= '0;
            integral_reg   <= '0;
            held_drive_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                err_prev2_reg  <= err_prev_reg;
                err_prev_reg   <= err;
                integral_reg   <= integral_next;
                held_drive_reg <= held_drive_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            drive_reg   <= held_drive_next;
            clamped_reg <= clamped_next;
        end
    end

    a_held_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> held_drive_reg == drive_reg)
        else $error("held drive differs from pending result");

    a_band_zero: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_band |=> drive_reg == '0 && !clamped_reg)
        else $error("dead band result not zero");

    a_clamp_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && clamped_reg |->
            (RAW_W'(drive_reg) == lim_pos) || (RAW_W'(drive_reg) == lim_neg))
        else $error("clamped result not at limit");

    a_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> RAW_W'(drive_reg) <= lim_pos && RAW_W'(drive_reg) >= lim_neg)
        else $error("result beyond drive limit");

endmodule

@@ sim/pid_controller_deadband_dual_mode_top_tb.sv @@
// Self-checking bench for the dead-band PID controller: directed table, then randomized
// phases across gains, limits, dead bands and both loop forms. Depends on pidc_pkg and
// pid_controller_deadband_dual_mode_top.
module pid_controller_deadband_dual_mode_top_tb;
    import pidc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CYCLE_LIMIT = 200000;
    localparam int     RAND_PHASES = 12;
    localparam int     DIR_ROWS    = 39;
    localparam longint ACC_HI      = (longint'(1) <<< (ACC_BITS - 1)) - 1;
    localparam longint ACC_LO      = -ACC_HI - 1;

    typedef struct packed
    {
        logic signed [SAMPLE_BITS-1:0] drive;
        logic                          clamped;
    } drive_result_t;

    typedef enum logic [1:0]
    {
        ROW_WRITE,
        ROW_PREDICT,
        ROW_CHECKED
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t   kind;
        cfg_idx_t    idx;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] drive;
        logic        clamped;
    } stim_row_t;

    typedef struct packed
    {
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
        logic [14:0] lim;
        logic [15:0] dz;
        loop_mode_t  mode;
    } pid_settings_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    cfg_idx_t                      cfg_index;
    logic [CFG_DATA_BITS-1:0]      cfg_wdata;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] measured;
    logic signed [SAMPLE_BITS-1:0] target;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [SAMPLE_BITS-1:0] drive;
    logic                          clamped;

    // controller copy: configuration and loop state
    logic signed [GAIN_BITS-1:0]   kp_reg     = '0;
    logic signed [GAIN_BITS-1:0]   ki_reg     = '0;
    logic signed [GAIN_BITS-1:0]   kd_reg     = '0;
    logic [LIMIT_BITS-1:0]         lim_reg    = LIMIT_RESET;
    logic [DZONE_BITS-1:0]         dz_reg     = '0;
    loop_mode_t                    mode_reg   = MODE_POSITIONAL;
    logic signed [ERR_W-1:0]       err_d1     = '0;
    logic signed [ERR_W-1:0]       err_d2     = '0;
    logic signed [ACC_BITS-1:0]    integ_sum  = '0;
    logic signed [SAMPLE_BITS-1:0] last_drive = '0;

    drive_result_t pending_drive_q[$];
    bit            use_fixed;
    drive_result_t fixed_result;
    bit            no_idle;
    int            rx_hold_left;
    int            mismatch_count;
    int            cycle_count;

    stim_row_t dir_tbl [DIR_ROWS] = '{
        '{ROW_CHECKED, CFG_PROP_GAIN,   16'h0000, 16'h0000, 16'h0000, 1'b0},
        '{ROW_CHECKED, CFG_PROP_GAIN,   16'h8000, 16'h7FFF, 16'h0000, 1'b0},
        '{ROW_WRITE,   CFG_PROP_GAIN,   16'h0100, 16'h0000, 16'h0000, 1'b0},
        '{ROW_CHECKED, CFG_PROP_GAIN,   16'h8000, 16'h7FFF, 16'h7FFF, 1'b1},
        '{ROW_CHECKED, CFG_PROP_GAIN,   16'h7FFF, 16'h8000, 16'h8001, 1'b1},
        '{ROW_CHECKED, CFG_PROP_GAIN,   16'h0000, 16'h0064, 16'h0064, 1'b0},
        '{ROW_WRITE,   CFG_PROP_GAIN,   16'h0080, 16'h0000, 16'h0000, 1'b0},
        '{ROW_CHECKED, CFG_PROP_GAIN,   16'h0000, 16'hFFFF, 16'hFFFF, 1'b0},
        '{ROW_CHECKED, CFG_PROP_GAIN,   16'h0000, 16'h0001, 16'h0000, 1'b0},
        '{ROW_WRITE,   CFG_DRIVE_LIMIT, 16'h0000, 16'h0000, 16'h0000, 1'b0},
        '{ROW_CHECKED, CFG_PROP_GAIN,   16'h0000, 16'h000A, 16'h0000, 1'b1},
        '{ROW_CHECKED, CFG_PROP_GAIN,   16'h0000, 16'h0001, 16'h0000, 1'b0},
        '{ROW_WRITE,   CFG_DRIVE_LIMIT, 16'h7FFF, 16'h0000, 16'h0000, 1'b0},
        '{ROW_WRITE,   CFG_DEAD_ZONE,   16'h0064, 16'h0000, 16'h0000, 1'b0},
        '{ROW_CHECKED, CFG_PROP_GAIN,   16'h0000, 16'h0063, 16'h0000, 1'b0},
        '{ROW_CHECKED, CFG_PROP_GAIN,   16'h0000, 16'h0064, 16'h0032, 1'b0},
        '{ROW_CHECKED, CFG_PROP_GAIN,   16'h0000, 16'hFF9D, 16'h0000, 1'b0},
        '{ROW_WRITE,   CFG_DEAD_ZONE,   16'hFFFF, 16'h0000, 16'h0000, 1'b0},
        '{ROW_CHECKED, CFG_PROP_GAIN,   16'h8000, 16'h7FFF, 16'h7FFF, 1'b0},
        '{ROW_CHECKED, CFG_PROP_GAIN,   16'h7FFF, 16'h8000, 16'h8001, 1'b1},
        '{ROW_CHECKED, CFG_PROP_GAIN,   16'h0000, 16'h1234, 16'h0000, 1'b0},
        '{ROW_WRITE,   CFG_DEAD_ZONE,   16'h0000, 16'h0000, 16'h0000, 1'b0},
        '{ROW_CHECKED, CFG_PROP_GAIN,   16'h0000, 16'h0100, 16'h0080, 1'b0},
        '{ROW_WRITE,   CFG_LOOP_MODE,   16'h0001, 16'h0000, 16'h0000, 1'b0},
        '{ROW_WRITE,   CFG_PROP_GAIN,   16'h0100, 16'h0000, 16'h0000, 1'b0},
        '{ROW_WRITE,   CFG_INTEG_GAIN,  16'h0040, 16'h0000, 16'h0000, 1'b0},
        '{ROW_WRITE,   CFG_DERIV_GAIN,  16'hFF00, 16'h0000, 16'h0000, 1'b0},
        '{ROW_PREDICT, CFG_PROP_GAIN,   16'h0000, 16'h00C8, 16'h0000, 1'b0},
        '{ROW_PREDICT, CFG_PROP_GAIN,   16'h0000, 16'h012C, 16'h0000, 1'b0},
        '{ROW_PREDICT, CFG_PROP_GAIN,   16'h0064, 16'h0032, 16'h0000, 1'b0},
        '{ROW_PREDICT, CFG_PROP_GAIN,   16'h0000, 16'h0000, 16'h0000, 1'b0},
        '{ROW_PREDICT, CFG_PROP_GAIN,   16'h8000, 16'h7FFF, 16'h0000, 1'b0},
        '{ROW_WRITE,   CFG_LOOP_MODE,   16'h0000, 16'h0000, 16'h0000, 1'b0},
        '{ROW_WRITE,   CFG_PROP_GAIN,   16'h8000, 16'h0000, 16'h0000, 1'b0},
        '{ROW_WRITE,   CFG_INTEG_GAIN,  16'h7FFF, 16'h0000, 16'h0000, 1'b0},
        '{ROW_WRITE,   CFG_DERIV_GAIN,  16'h8000, 16'h0000, 16'h0000, 1'b0},
        '{ROW_PREDICT, CFG_PROP_GAIN,   16'h7FFF, 16'h8000, 16'h0000, 1'b0},
        '{ROW_PREDICT, CFG_PROP_GAIN,   16'h8000, 16'h7FFF, 16'h0000, 1'b0},
        '{ROW_PREDICT, CFG_PROP_GAIN,   16'h0005, 16'hFFF9, 16'h0000, 1'b0}
    };

    pid_controller_deadband_dual_mode_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .measured  (measured),
        .target    (target),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive),
        .clamped   (clamped)
    );

    function automatic drive_result_t pid_step(input logic signed [SAMPLE_BITS-1:0] meas,
                                               input logic signed [SAMPLE_BITS-1:0] tgt);
        longint        e;
        longint        ep;
        longint        ep2;
        longint        acc;
        longint        raw;
        longint        lim_v;
        drive_result_t r;
        e     = longint'(tgt) - longint'(meas);
        ep    = longint'(err_d1);
        ep2   = longint'(err_d2);
        lim_v = longint'(lim_reg);
        r.drive   = '0;
        r.clamped = 1'b0;
        if ((e < 0 ? -e : e) >= longint'(dz_reg))
        begin
            acc = longint'(integ_sum) + longint'(ki_reg) * e;
            if (acc > ACC_HI)
                acc = ACC_HI;
            if (acc < ACC_LO)
                acc = ACC_LO;
            integ_sum = acc[ACC_BITS-1:0];
            if (mode_reg == MODE_POSITIONAL)
                raw = (longint'(kp_reg) * e + longint'(integ_sum)
                       + longint'(kd_reg) * (e - ep)) >>> GAIN_FRAC_BITS;
            else
                raw = longint'(last_drive)
                      + ((longint'(kp_reg) * (e - ep) + longint'(ki_reg) * e
                          + longint'(kd_reg) * (e - 2 * ep + ep2)) >>> GAIN_FRAC_BITS);
            if (raw > lim_v)
            begin
                raw       = lim_v;
                r.clamped = 1'b1;
            end
            if (raw < -lim_v)
            begin
                raw       = -lim_v;
                r.clamped = 1'b1;
            end
            r.drive = raw[SAMPLE_BITS-1:0];
        end
        last_drive = r.drive;
        err_d2     = err_d1;
        err_d1     = e[ERR_W-1:0];
        return r;
    endfunction

    function automatic void flag_error(input string msg);
        if (mismatch_count < 10)
            $display("ERROR cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(0, 2047) - 1024);
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // config shadow, result check, and prediction per accepted transaction
    always @(posedge clk)
    begin
        drive_result_t want;
        drive_result_t got;
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_PROP_GAIN:   kp_reg   = cfg_wdata;
                    CFG_INTEG_GAIN:  ki_reg   = cfg_wdata;
                    CFG_DERIV_GAIN:  kd_reg   = cfg_wdata;
                    CFG_DRIVE_LIMIT: lim_reg  = cfg_wdata[LIMIT_BITS-1:0];
                    CFG_DEAD_ZONE:   dz_reg   = cfg_wdata[DZONE_BITS-1:0];
                    CFG_LOOP_MODE:   mode_reg = loop_mode_t'(cfg_wdata[0]);
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got.drive   = drive;
                got.clamped = clamped;
                if (pending_drive_q.size() == 0)
                    flag_error($sformatf("result drive %0d with nothing pending", got.drive));
                else
                begin
                    want = pending_drive_q.pop_front();
                    if (got.drive !== want.drive)
                        flag_error($sformatf("drive exp %0d got %0d", want.drive, got.drive));
                    if (got.clamped !== want.clamped)
                        flag_error($sformatf("clamped exp %0b got %0b",
                                             want.clamped, got.clamped));
                end
            end
            if (in_valid && in_ready)
            begin
                want = pid_step(measured, target);
                pending_drive_q.push_back(use_fixed ? fixed_result : want);
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                out_ready <= 1'b0;
                rx_hold_left--;
            end
            else if (no_idle)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 20);
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_sample(input logic [15:0] m, input logic [15:0] t,
                               input bit fixed, input logic [15:0] fd, input logic fc);
        int gap;
        gap = 0;
        if (!no_idle)
            while ($urandom_range(0, 99) < 20)
                gap++;
        use_fixed            = fixed;
        fixed_result.drive   = fd;
        fixed_result.clamped = fc;
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        measured <= m;
        target   <= t;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val, input bit more);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        if (!more)
            cfg_wr_en <= 1'b0;
    endtask

    task automatic settle(input bit steady);
        in_valid <= 1'b0;
        while (pending_drive_q.size() != 0)
            @(negedge clk);
        repeat (2) @(posedge clk);
        no_idle = steady;
        @(negedge clk);
    endtask

    task automatic apply_settings(input pid_settings_t s);
        write_reg(CFG_PROP_GAIN,   s.kp,          1'b1);
        write_reg(CFG_INTEG_GAIN,  s.ki,          1'b1);
        write_reg(CFG_DERIV_GAIN,  s.kd,          1'b1);
        write_reg(CFG_DRIVE_LIMIT, {1'b0, s.lim}, 1'b1);
        write_reg(CFG_DEAD_ZONE,   s.dz,          1'b1);
        write_reg(CFG_LOOP_MODE,   16'(s.mode),   1'b0);
    endtask

    initial
    begin
        pid_settings_t                 cfg;
        logic signed [SAMPLE_BITS-1:0] setpt;
        logic signed [SAMPLE_BITS-1:0] m;
        logic signed [SAMPLE_BITS-1:0] t;
        int                            mi;
        int                            d;
        int                            span;
        int                            len;
        bit                            more;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = CFG_PROP_GAIN;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        measured       = '0;
        target         = '0;
        use_fixed      = 1'b0;
        fixed_result   = '0;
        no_idle        = 1'b0;
        rx_hold_left   = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_tbl[i].kind == ROW_WRITE)
            begin
                if (i > 0 && dir_tbl[i-1].kind != ROW_WRITE)
                    settle(1'b0);
                more = (i + 1 < DIR_ROWS) && (dir_tbl[i+1].kind == ROW_WRITE);
                write_reg(dir_tbl[i].idx, dir_tbl[i].a, more);
            end
            else
                send_sample(dir_tbl[i].a, dir_tbl[i].b, dir_tbl[i].kind == ROW_CHECKED,
                            dir_tbl[i].drive, dir_tbl[i].clamped);
        end

        // phases 0 and 1 drive the integral into both saturation rails
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            settle(p == 3);
            if (p < 2)
            begin
                cfg.kp   = '0;
                cfg.ki   = (p == 0) ? 16'h7FFF : 16'h8000;
                cfg.kd   = '0;
                cfg.lim  = '1;
                cfg.dz   = '0;
                cfg.mode = MODE_POSITIONAL;
                len      = (p == 0) ? 280 : 560;
            end
            else
            begin
                cfg.kp = pick_gain();
                cfg.ki = pick_gain();
                cfg.kd = pick_gain();
                case ($urandom_range(0, 3))
                    0:       cfg.lim = '0;
                    1:       cfg.lim = '1;
                    2:       cfg.lim = 15'($urandom_range(1, 255));
                    default: cfg.lim = 15'($urandom);
                endcase
                case ($urandom_range(0, 7))
                    0, 1:    cfg.dz = '0;
                    2:       cfg.dz = '1;
                    default: cfg.dz = 16'($urandom_range(0, 400));
                endcase
                cfg.mode = loop_mode_t'($urandom_range(0, 1));
                len      = 110;
            end
            apply_settings(cfg);
            setpt = 16'($urandom);
            span  = int'(cfg.dz) + 64;
            for (int k = 0; k < len; k++)
            begin
                if (p == 4 && k == 30)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    rx_hold_left = 300;
                    @(negedge clk);
                end
                if (p == 6 && k == 55)
                    settle(1'b0);
                if (p < 2 && $urandom_range(0, 9) != 0)
                begin
                    m = 16'sh8000 + 16'($urandom_range(0, 15));
                    t = 16'sh7FFF - 16'($urandom_range(0, 15));
                end
                else
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5:
                        begin
                            d  = int'($urandom_range(0, 2 * span)) - span;
                            mi = int'(setpt) + d;
                            if (mi > 32767)
                                mi = 32767;
                            if (mi < -32768)
                                mi = -32768;
                            m = 16'(mi);
                            t = setpt;
                        end
                        6, 7, 8:
                        begin
                            m = 16'($urandom);
                            t = 16'($urandom);
                        end
                        default:
                        begin
                            m = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                            t = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                        end
                    endcase
                end
                send_sample(m, t, 1'b0, 16'h0000, 1'b0);
            end
        end

        settle(1'b0);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
